// ----- sv/ssr_pkg.sv -----
package ssr_pkg;

	// Longest pattern or replacement the register map can hold
	localparam int unsigned BYTES_MAX = 16;
	localparam int unsigned STR_W = 8 * BYTES_MAX;

	localparam logic [7:0] NEWLINE = 8'd10;

	// Configuration register indexes
	localparam logic [2:0] REG_PAT_LO = 3'd0;
	localparam logic [2:0] REG_PAT_HI = 3'd1;
	localparam logic [2:0] REG_PAT_LEN = 3'd2;
	localparam logic [2:0] REG_REP_LO = 3'd3;
	localparam logic [2:0] REG_REP_HI = 3'd4;
	localparam logic [2:0] REG_REP_LEN = 3'd5;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       stream_end;
	} text_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} result_t;

	// Byte i of a 16-byte string, byte 0 in the low bits
	function automatic logic [7:0] byte_at(input logic [STR_W-1:0] str, input logic [3:0] idx);
		byte_at = str[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ----- sv/stream_substring_replace.sv -----
// Streaming find-and-replace, leftmost non-overlapping, one text byte per request.
// Channels: text (text_valid/text_ready, text_req) carries one byte or an
// end-of-stream mark; result (result_valid/result_ready, result_data) carries the
// transformed bytes, last_of_run set on the final byte caused by one request.
// cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes pattern and replacement;
// it is taken only while the sequencer is idle, ahead of a waiting text request.
// An accepted byte that extends a partial match emits nothing; one that completes
// it goes straight to emission of the replacement, if any. A mismatch after held
// bytes runs the shared shifted-compare unit (one candidate shift per cycle, in
// increasing order), then emits one byte per cycle while the output slot is free.
// The single output register lets the next request be taken while the last
// result still waits; if the receiver stalls, emission halts and text_ready
// stays low until the last pending result byte has entered the output register.
// Reset clears the match state, the line flag and all configuration to zero.
module stream_substring_replace #(
	parameter int unsigned PATTERN_MAX = 16,
	parameter int unsigned REPLACE_MAX = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  ssr_pkg::text_req_t    text_req,
	output logic                  result_valid,
	input  logic                  result_ready,
	output ssr_pkg::result_t      result_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_data
);

	localparam logic [4:0] PLIM = 5'((PATTERN_MAX < ssr_pkg::BYTES_MAX) ?
		PATTERN_MAX : ssr_pkg::BYTES_MAX);
	localparam logic [4:0] RLIM = 5'((REPLACE_MAX < ssr_pkg::BYTES_MAX) ?
		REPLACE_MAX : ssr_pkg::BYTES_MAX);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [ssr_pkg::STR_W-1:0] pat_q;
	logic [ssr_pkg::STR_W-1:0] rep_q;
	logic [4:0] pat_len_q;
	logic [4:0] rep_len_q;
	logic [4:0] k_q;
	logic       line_q;
	logic [7:0] c_q;
	logic [4:0] s_q;
	logic [4:0] idx_q;
	logic [4:0] cnt_q;
	logic       src_rep_q;
	logic       tail_q;
	logic [7:0] tail_byte_q;
	logic       out_valid_q;
	ssr_pkg::result_t out_q;

	logic [4:0] plen;
	logic [4:0] rlen;
	logic [4:0] k_eff;
	logic [4:0] k_next;
	logic       text_acc;
	logic       cfg_acc;
	logic       slot_free;
	logic       emit_fire;
	logic [7:0] pat_k;

	// shared shifted-compare unit signals
	logic [4:0] rem;
	logic [ssr_pkg::STR_W-1:0] diff;
	logic [ssr_pkg::STR_W-1:0] mask;
	logic       shift_ok;

	// emit source byte
	logic [7:0] src_byte;

	assign plen = (pat_len_q > PLIM) ? PLIM : pat_len_q;
	assign rlen = (rep_len_q > RLIM) ? RLIM : rep_len_q;
	assign k_eff = (k_q >= plen) ? 5'd0 : k_q;
	assign k_next = k_eff + 5'd1;
	assign pat_k = ssr_pkg::byte_at(pat_q, k_eff[3:0]);

	// a pending register write goes ahead of text
	assign text_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign text_acc = text_valid && text_ready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign slot_free = !out_valid_q || result_ready;
	assign emit_fire = (state_q == ST_EMIT) && slot_free;

	assign result_valid = out_valid_q;
	assign result_data = out_q;

	// Candidate shift s: pattern[s..k-1] must equal pattern[0..k-1-s] and c == pattern[k-s]
	assign rem = k_q - s_q;
	assign diff = pat_q ^ (pat_q >> {s_q[3:0], 3'b000});
	always_comb begin
		for (int j = 0; j < ssr_pkg::BYTES_MAX; j++) begin
			mask[8*j +: 8] = {8{5'(j) < rem}};
		end
	end
	assign shift_ok = ((diff & mask) == '0) &&
		(c_q == ssr_pkg::byte_at(pat_q, rem[3:0]));

	assign src_byte = src_rep_q ? ssr_pkg::byte_at(rep_q, idx_q[3:0]) :
		ssr_pkg::byte_at(pat_q, idx_q[3:0]);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			rep_q <= '0;
			pat_len_q <= '0;
			rep_len_q <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				ssr_pkg::REG_PAT_LO: pat_q[63:0] <= cfg_data;
				ssr_pkg::REG_PAT_HI: pat_q[127:64] <= cfg_data;
				ssr_pkg::REG_PAT_LEN: pat_len_q <= cfg_data[4:0];
				ssr_pkg::REG_REP_LO: rep_q[63:0] <= cfg_data;
				ssr_pkg::REG_REP_HI: rep_q[127:64] <= cfg_data;
				ssr_pkg::REG_REP_LEN: rep_len_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Sequencer: decide, search shifts, emit bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			line_q <= 1'b0;
			c_q <= '0;
			s_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			src_rep_q <= 1'b0;
			tail_q <= 1'b0;
			tail_byte_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (result_ready && !emit_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_acc && (cfg_index == ssr_pkg::REG_PAT_LO ||
						cfg_index == ssr_pkg::REG_PAT_HI ||
						cfg_index == ssr_pkg::REG_PAT_LEN)) begin
						k_q <= '0;
					end
					if (text_acc) begin
						c_q <= text_req.text_byte;
						idx_q <= '0;
						if (text_req.stream_end || text_req.text_byte == ssr_pkg::NEWLINE) begin
							// flush held prefix, close the line
							src_rep_q <= 1'b0;
							cnt_q <= k_eff;
							tail_q <= !text_req.stream_end || line_q;
							tail_byte_q <= ssr_pkg::NEWLINE;
							k_q <= '0;
							line_q <= 1'b0;
							if (k_eff != '0 || !text_req.stream_end || line_q) begin
								state_q <= ST_EMIT;
							end
						end else begin
							tail_byte_q <= text_req.text_byte;
							src_rep_q <= (plen != '0) && (text_req.text_byte == pat_k) &&
								(k_next == plen);
							line_q <= 1'b1;
							if (plen == '0) begin
								cnt_q <= '0;
								tail_q <= 1'b1;
								k_q <= '0;
								state_q <= ST_EMIT;
							end else if (text_req.text_byte == pat_k) begin
								if (k_next == plen) begin
									k_q <= '0;
									cnt_q <= rlen;
									tail_q <= 1'b0;
									if (rlen != '0) begin
										state_q <= ST_EMIT;
									end
								end else begin
									k_q <= k_next;
								end
							end else if (k_eff == '0) begin
								cnt_q <= '0;
								tail_q <= 1'b1;
								k_q <= '0;
								state_q <= ST_EMIT;
							end else begin
								k_q <= k_eff;
								s_q <= 5'd1;
								state_q <= ST_SEARCH;
							end
						end
					end
				end
				ST_SEARCH: begin
					if (shift_ok) begin
						cnt_q <= s_q;
						tail_q <= 1'b0;
						k_q <= k_q + 5'd1 - s_q;
						state_q <= ST_EMIT;
					end else if (s_q == k_q) begin
						cnt_q <= k_q;
						tail_q <= 1'b1;
						k_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						s_q <= s_q + 5'd1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (idx_q < cnt_q) begin
							out_q.out_byte <= src_byte;
							out_q.last_of_run <= (idx_q + 5'd1 == cnt_q) && !tail_q;
							idx_q <= idx_q + 5'd1;
							if (idx_q + 5'd1 == cnt_q && !tail_q) begin
								state_q <= ST_IDLE;
							end
						end else begin
							out_q.out_byte <= tail_byte_q;
							out_q.last_of_run <= 1'b1;
							tail_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Held prefix is always shorter than the active pattern between requests
	a_prefix_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (k_q == '0 || k_q < plen))
		else $error("held prefix not shorter than pattern");

	// Shift search stays within the held prefix
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (s_q != '0 && s_q <= k_q && k_q < 5'd16))
		else $error("shift candidate out of range");

	// Emission makes progress whenever the output slot is free
	a_emit_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && slot_free) |=> result_valid)
		else $error("emit stalled with free output slot");

	// Nothing is emitted past the end of the run
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q < cnt_q || tail_q))
		else $error("emit state with nothing left to send");

endmodule

// ----- tb/sv/tb_stream_substring_replace.sv -----
module tb_stream_substring_replace;
	timeunit 1ns;
	timeprecision 1ps;

	// Instance uses the default parameters
	localparam int PAT_CAP = 16;
	localparam int REP_CAP = 16;

	localparam int RANDOM_ITEMS = 145;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PCT = 28;

	// Indexes outside the register map
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_C = 8'h63;
	localparam logic [7:0] CH_X = 8'h78;

	typedef enum logic {ROW_TEXT, ROW_WRITE} row_kind_e;

	typedef struct {
		row_kind_e  kind;
		ssr_pkg::text_req_t req;
		logic [2:0] reg_index;
		logic [63:0] reg_value;
		bit         typed;
		int         typed_count;
		logic [7:0] typed_byte;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        text_valid;
	logic        text_ready;
	ssr_pkg::text_req_t text_req;
	logic        result_valid;
	logic        result_ready;
	ssr_pkg::result_t result_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	stream_substring_replace i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_req    (text_req),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data (result_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow copy of the registers and match state
	logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
	logic [4:0]  pat_len, rep_len;
	logic [4:0]  held_count;
	bit          line_open;

	ssr_pkg::result_t expected_bytes[$];
	logic [7:0]  run_bytes[$];
	plan_row_t   directed_plan[$];

	int  mismatches = 0;
	int  bytes_checked = 0;
	int  items_sent = 0;
	int  reg_writes = 0;
	int  cycle_count = 0;
	bit  calm = 1'b0;
	bit  hold_request = 1'b0;

	function automatic logic [7:0] str_byte(input logic [63:0] lo, input logic [63:0] hi,
			input int idx);
		int i;
		i = idx & 15;
		return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
	endfunction

	function automatic logic [7:0] pat_byte(input int idx);
		return str_byte(pat_lo, pat_hi, idx);
	endfunction

	function automatic int clamp_length(input logic [4:0] len, input int cap);
		int lim;
		lim = (cap < 16) ? cap : 16;
		return (int'(len) > lim) ? lim : int'(len);
	endfunction

	// Register write as the block sees it; pattern writes drop a partial match
	function automatic void apply_reg_write(input logic [2:0] idx, input logic [63:0] val);
		case (idx)
			ssr_pkg::REG_PAT_LO: begin
				pat_lo = val;
				held_count = '0;
			end
			ssr_pkg::REG_PAT_HI: begin
				pat_hi = val;
				held_count = '0;
			end
			ssr_pkg::REG_PAT_LEN: begin
				pat_len = val[4:0];
				held_count = '0;
			end
			ssr_pkg::REG_REP_LO: rep_lo = val;
			ssr_pkg::REG_REP_HI: rep_hi = val;
			ssr_pkg::REG_REP_LEN: rep_len = val[4:0];
			default: ;
		endcase
	endfunction

	// Bytes released by one text request, left in run_bytes
	function automatic void replace_step(input ssr_pkg::text_req_t req);
		logic [7:0] c;
		int plen, rlen, k, s, i;
		bit ok;
		c = req.text_byte;
		plen = clamp_length(pat_len, PAT_CAP);
		rlen = clamp_length(rep_len, REP_CAP);
		k = held_count;
		if (k >= plen)
			k = 0;
		run_bytes.delete();
		if (req.stream_end) begin
			for (i = 0; i < k; i++)
				run_bytes.push_back(pat_byte(i));
			if (line_open)
				run_bytes.push_back(ssr_pkg::NEWLINE);
			k = 0;
			line_open = 1'b0;
		end else if (c == ssr_pkg::NEWLINE) begin
			for (i = 0; i < k; i++)
				run_bytes.push_back(pat_byte(i));
			run_bytes.push_back(ssr_pkg::NEWLINE);
			k = 0;
			line_open = 1'b0;
		end else begin
			line_open = 1'b1;
			if (plen == 0) begin
				run_bytes.push_back(c);
			end else if (c == pat_byte(k)) begin
				k++;
				if (k == plen) begin
					for (i = 0; i < rlen; i++)
						run_bytes.push_back(str_byte(rep_lo, rep_hi, i));
					k = 0;
				end
			end else begin
				// smallest shift that leaves held bytes plus c as a pattern prefix
				for (s = 1; s <= k; s++) begin
					ok = (c == pat_byte(k - s));
					for (i = s; ok && i < k; i++)
						if (pat_byte(i) != pat_byte(i - s))
							ok = 1'b0;
					if (ok)
						break;
				end
				if (s <= k) begin
					for (i = 0; i < s; i++)
						run_bytes.push_back(pat_byte(i));
					k = k + 1 - s;
				end else begin
					for (i = 0; i < k; i++)
						run_bytes.push_back(pat_byte(i));
					run_bytes.push_back(c);
					k = 0;
				end
			end
		end
		held_count = k[4:0];
	endfunction

	// Wait for all results, then let any silent work finish
	task automatic wait_quiet();
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		text_valid <= 1'b0;
		wait_quiet();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg_write(idx, val);
		reg_writes++;
	endtask

	// Offer one request; valid stays high after acceptance unless a gap follows
	task automatic send_text(input ssr_pkg::text_req_t req, input bit typed,
			input int typed_count, input logic [7:0] typed_byte);
		int i;
		if (!calm)
			while ($urandom_range(99) < IDLE_PCT) begin
				text_valid <= 1'b0;
				@(posedge clk);
			end
		text_req <= req;
		text_valid <= 1'b1;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		items_sent++;
		replace_step(req);
		if (typed) begin
			if (typed_count > 0)
				expected_bytes.push_back('{out_byte: typed_byte, last_of_run: 1'b1});
		end else begin
			for (i = 0; i < run_bytes.size(); i++)
				expected_bytes.push_back('{out_byte: run_bytes[i],
					last_of_run: (i == run_bytes.size() - 1)});
		end
	endtask

	function automatic ssr_pkg::text_req_t mk_text(input logic [7:0] b, input logic fin);
		return '{text_byte: b, stream_end: fin};
	endfunction

	function automatic void add_text(input logic [7:0] b, input logic fin);
		directed_plan.push_back('{ROW_TEXT, mk_text(b, fin), 3'd0, 64'd0, 1'b0, 0, 8'd0});
	endfunction

	function automatic void add_typed(input logic [7:0] b, input logic fin, input int n,
			input logic [7:0] want);
		directed_plan.push_back('{ROW_TEXT, mk_text(b, fin), 3'd0, 64'd0, 1'b1, n, want});
	endfunction

	function automatic void add_write(input logic [2:0] idx, input logic [63:0] val);
		directed_plan.push_back('{ROW_WRITE, mk_text(8'd0, 1'b0), idx, val, 1'b0, 0, 8'd0});
	endfunction

	function automatic void build_plan();
		// reset state: empty pattern passes everything through
		add_typed(8'h00, 1'b0, 1, 8'h00);
		add_typed(8'hFF, 1'b0, 1, 8'hFF);
		add_typed(ssr_pkg::NEWLINE, 1'b0, 1, ssr_pkg::NEWLINE);
		add_typed(8'hA5, 1'b1, 0, 8'h00);
		add_typed(CH_X, 1'b0, 1, CH_X);
		add_typed(8'h5A, 1'b1, 1, ssr_pkg::NEWLINE);
		// pattern "aab", replacement "XYZ"
		add_write(ssr_pkg::REG_PAT_LO, 64'h0000_0000_0062_6161);
		add_write(ssr_pkg::REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		add_write(ssr_pkg::REG_PAT_LEN, 64'd3);
		add_write(ssr_pkg::REG_REP_LO, 64'h0000_0000_005A_5958);
		add_write(ssr_pkg::REG_REP_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		add_write(ssr_pkg::REG_REP_LEN, 64'd3);
		// overlap shift, full match, plain mismatch, flush at newline and at end
		add_text(CH_A, 1'b0);
		add_text(CH_A, 1'b0);
		add_text(CH_A, 1'b0);
		add_text(CH_B, 1'b0);
		add_text(CH_A, 1'b0);
		add_text(CH_C, 1'b0);
		add_text(CH_A, 1'b0);
		add_text(CH_A, 1'b0);
		add_text(ssr_pkg::NEWLINE, 1'b0);
		add_text(CH_A, 1'b0);
		add_text(8'h00, 1'b1);
		// rewriting the pattern drops the held prefix
		add_text(CH_A, 1'b0);
		add_text(CH_A, 1'b0);
		add_write(ssr_pkg::REG_PAT_LEN, 64'd3);
		add_typed(ssr_pkg::NEWLINE, 1'b0, 1, ssr_pkg::NEWLINE);
		// empty replacement deletes; a line deleted whole still ends in newline
		add_write(ssr_pkg::REG_REP_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
		add_typed(CH_A, 1'b0, 0, 8'h00);
		add_typed(CH_A, 1'b0, 0, 8'h00);
		add_typed(CH_B, 1'b0, 0, 8'h00);
		add_typed(ssr_pkg::NEWLINE, 1'b0, 1, ssr_pkg::NEWLINE);
		// writes to unmapped indexes change nothing
		add_write(REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
		add_write(REG_SPARE_7, 64'd0);
		add_typed(CH_C, 1'b0, 1, CH_C);
		add_text(ssr_pkg::NEWLINE, 1'b0);
	endfunction

	// New pattern and replacement for one random phase
	task automatic program_setting(input int phase);
		logic [7:0] letters[2];
		logic [127:0] pat_str;
		logic [127:0] rep_str;
		logic [4:0] plen_code, rlen_code;
		int i, r;
		letters[0] = 8'($urandom_range(255));
		letters[1] = 8'($urandom_range(255));
		for (i = 0; i < 16; i++)
			pat_str[8*i +: 8] = ($urandom_range(4) != 0) ?
				letters[$urandom_range(1)] : 8'($urandom_range(255));
		rep_str = {$urandom, $urandom, $urandom, $urandom};
		r = $urandom_range(99);
		if (r < 65)
			plen_code = 5'($urandom_range(1, 5));
		else if (r < 85)
			plen_code = 5'($urandom_range(6, 16));
		else if (r < 93)
			plen_code = 5'd0;
		else
			plen_code = 5'($urandom_range(17, 31));
		rlen_code = ($urandom_range(99) < 80) ? 5'($urandom_range(16)) :
			5'($urandom_range(17, 31));
		case (phase)
			0: begin
				plen_code = 5'd31;
				rlen_code = 5'd16;
			end
			1: begin
				plen_code = 5'd16;
				rlen_code = 5'd20;
			end
			2: begin
				// newline inside the pattern: never matches
				plen_code = 5'd3;
				pat_str[15:8] = ssr_pkg::NEWLINE;
			end
			default: ;
		endcase
		// some phases change only the replacement, keeping any held prefix
		if (!(phase >= 5 && phase % 3 == 2)) begin
			write_reg(ssr_pkg::REG_PAT_LO, pat_str[63:0]);
			write_reg(ssr_pkg::REG_PAT_HI, pat_str[127:64]);
			write_reg(ssr_pkg::REG_PAT_LEN, {32'($urandom), 27'($urandom), plen_code});
		end
		write_reg(ssr_pkg::REG_REP_LO, rep_str[63:0]);
		write_reg(ssr_pkg::REG_REP_HI, rep_str[127:64]);
		write_reg(ssr_pkg::REG_REP_LEN, {32'($urandom), 27'($urandom), rlen_code});
	endtask

	// Mostly pattern runs and pattern bytes, with newlines, ends and noise
	task automatic random_text_burst(input int count);
		int made, r, n, i, plen;
		logic [7:0] b;
		made = 0;
		while (made < count) begin
			r = $urandom_range(99);
			plen = clamp_length(pat_len, PAT_CAP);
			if (r < 35 && plen > 0) begin
				n = ($urandom_range(2) != 0) ? plen : $urandom_range(1, plen);
				for (i = 0; i < n; i++) begin
					b = pat_byte(i);
					if (i == n - 1 && $urandom_range(3) == 0)
						b = 8'($urandom_range(255));
					send_text(mk_text(b, 1'b0), 1'b0, 0, 8'd0);
					made++;
				end
			end else begin
				if (r < 60 && plen > 0)
					b = pat_byte($urandom_range(plen - 1));
				else if (r < 70)
					b = ssr_pkg::NEWLINE;
				else
					b = 8'($urandom_range(255));
				send_text(mk_text(b, (r >= 70 && r < 74)), 1'b0, 0, 8'd0);
				made++;
			end
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		ssr_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual byte %h last %b",
					$time, result_data.out_byte, result_data.last_of_run);
			end else begin
				want = expected_bytes.pop_front();
				if (result_data.out_byte !== want.out_byte) begin
					mismatches++;
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, want.out_byte, result_data.out_byte);
				end
				if (result_data.last_of_run !== want.last_of_run) begin
					mismatches++;
					$display("%0t: last_of_run mismatch, expected %b, actual %b",
						$time, want.last_of_run, result_data.last_of_run);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, expected_bytes.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, none while calm, one long hold-off on request
	initial begin
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Sender
	initial begin
		int phase, directed_sent;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pat_lo = '0;
		pat_hi = '0;
		pat_len = '0;
		rep_lo = '0;
		rep_hi = '0;
		rep_len = '0;
		held_count = '0;
		line_open = 1'b0;
		build_plan();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (directed_plan[r]) begin
			if (directed_plan[r].kind == ROW_WRITE)
				write_reg(directed_plan[r].reg_index, directed_plan[r].reg_value);
			else
				send_text(directed_plan[r].req, directed_plan[r].typed,
					directed_plan[r].typed_count, directed_plan[r].typed_byte);
		end
		directed_sent = items_sent;

		// random phases
		phase = 0;
		while (items_sent - directed_sent < RANDOM_ITEMS) begin
			program_setting(phase);
			calm = (phase == 3);
			if (phase == 2)
				hold_request = 1'b1;
			random_text_burst($urandom_range(18, 28));
			phase++;
		end
		calm = 1'b0;
		send_text(mk_text(8'($urandom_range(255)), 1'b1), 1'b0, 0, 8'd0);
		text_valid <= 1'b0;
		wait_quiet();

		$display("Covered %0d text requests (%0d directed) over %0d settings, %0d register writes",
			items_sent, directed_sent, phase + 1, reg_writes);
		$display("Compared %0d result bytes, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/ssr_pkg.sv
sv/stream_substring_replace.sv
tb/sv/tb_stream_substring_replace.sv
